// ===== sv/mlk_pkg.sv =====
// ----------------------------------------------------------------------------
// Multi-list top-k keeper package
// Shared constants, request codes and the word types of the block.
// ----------------------------------------------------------------------------
package mlk_pkg;

    localparam int LISTS_DEF   = 4;
    localparam int LEADERS_DEF = 16;
    localparam int LEN_RESET   = 16;
    localparam int MAX_LISTS   = 4;
    localparam int ID_W        = 16;
    localparam int SCORE_W     = 32;
    localparam int LEN_CFG_W   = 5;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_READ   = 1'b1;

    typedef struct packed {
        logic                      req_type;
        logic [ID_W-1:0]           item_id;
        logic signed [SCORE_W-1:0] score_a;
        logic signed [SCORE_W-1:0] score_b;
        logic signed [SCORE_W-1:0] score_c;
        logic signed [SCORE_W-1:0] score_d;
        logic [1:0]                list_sel;
        logic [3:0]                rank_sel;
    } t_req;

    typedef struct packed {
        logic [ID_W-1:0]           out_id;
        logic signed [SCORE_W-1:0] out_score;
        logic                      out_valid;
        logic [MAX_LISTS-1:0]      kept_mask;
    } t_res;

    // Read-out of one lane at the requested rank.
    typedef struct packed {
        logic                      valid;
        logic [ID_W-1:0]           id;
        logic signed [SCORE_W-1:0] score;
    } t_lane_rd;

endpackage

// ===== sv/mlk_lane.sv =====
// ----------------------------------------------------------------------------
// Multi-list top-k keeper lane
// One sorted register row with its fill count: parallel compare and shift.
// ----------------------------------------------------------------------------
module mlk_lane
    import mlk_pkg::*;
#(
    parameter int LEADERS = LEADERS_DEF,
    localparam int FW     = $clog2(LEADERS + 1)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_ins,
    input  logic [ID_W-1:0]           i_id,
    input  logic signed [SCORE_W-1:0] i_score,
    input  logic [FW-1:0]             i_lim,
    input  logic                      i_clamp,
    input  logic [FW-1:0]             i_new_lim,
    input  logic [3:0]                i_rank,
    output logic                      o_kept,
    output t_lane_rd                  o_rd
);

    logic [ID_W-1:0]           r_ids    [LEADERS];
    logic signed [SCORE_W-1:0] r_scores [LEADERS];
    logic [FW-1:0]             r_fill;
    logic [FW-1:0]             n_fill;

    logic [LEADERS-1:0] w_before;
    logic [LEADERS-1:0] w_at;

    // w_before marks stored entries that stay ahead of the new one; the row is
    // sorted, so these form a run from rank zero.
    always_comb begin
        for (int k = 0; k < LEADERS; k++) begin
            w_before[k] = (FW'(k) < r_fill) && (r_scores[k] <= i_score);
        end
        w_at[0] = !w_before[0] && (FW'(0) < i_lim);
        for (int k = 1; k < LEADERS; k++) begin
            w_at[k] = !w_before[k] && (FW'(k) < i_lim) && w_before[k - 1];
        end
    end

    assign o_kept = |w_at;

    always_comb begin
        n_fill = r_fill;
        if (i_ins && o_kept) begin
            n_fill = (r_fill < i_lim) ? r_fill + FW'(1) : i_lim;
        end
        if (i_clamp && (r_fill > i_new_lim)) begin
            n_fill = i_new_lim;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    for (genvar k = 0; k < LEADERS; k++) begin : g_cell
        if (k == 0) begin : g_head
            always_ff @(posedge i_clk) begin
                if (i_ins && w_at[k]) begin
                    r_ids[k]    <= i_id;
                    r_scores[k] <= i_score;
                end
            end
        end else begin : g_body
            always_ff @(posedge i_clk) begin
                if (i_ins && o_kept) begin
                    if (w_at[k]) begin
                        r_ids[k]    <= i_id;
                        r_scores[k] <= i_score;
                    end else if (!w_before[k]) begin
                        r_ids[k]    <= r_ids[k - 1];
                        r_scores[k] <= r_scores[k - 1];
                    end
                end
            end
        end
    end

    always_comb begin
        o_rd = '0;
        for (int k = 0; k < LEADERS; k++) begin
            if ((int'(i_rank) == k) && (FW'(k) < r_fill)) begin
                o_rd.valid = 1'b1;
                o_rd.id    = r_ids[k];
                o_rd.score = r_scores[k];
            end
        end
    end

endmodule

// ===== sv/mlk_merge.sv =====
// ----------------------------------------------------------------------------
// Multi-list top-k keeper merge stage
// Gathers the lanes' kept flags and read-outs into the registered result.
// ----------------------------------------------------------------------------
module mlk_merge
    import mlk_pkg::*;
#(
    parameter int LISTS = LISTS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic             i_req_type,
    input  logic [1:0]       i_list_sel,
    input  logic [LISTS-1:0] i_kept,
    input  t_lane_rd         i_rd [LISTS],
    output logic             o_done,
    output t_res             o_res
);

    t_res n_res;

    always_comb begin
        n_res = '0;
        if (i_req_type == REQ_INSERT) begin
            for (int l = 0; l < LISTS; l++) begin
                n_res.kept_mask[l] = i_kept[l];
            end
        end else begin
            for (int l = 0; l < LISTS; l++) begin
                if (int'(i_list_sel) == l) begin
                    n_res.out_valid = i_rd[l].valid;
                    n_res.out_id    = i_rd[l].id;
                    n_res.out_score = i_rd[l].score;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            o_res <= n_res;
        end
    end

endmodule

// ===== sv/multi_list_top_k_keeper.sv =====
// ----------------------------------------------------------------------------
// Multi-list top-k keeper
// Keeps one ascending leaderboard of the smallest scores per list.
// ----------------------------------------------------------------------------
// Result: a result word appears on o_res with o_done high in the cycle after
// the request word is accepted, and is shown for exactly one cycle.
// Throughput: one request word per cycle unless busy; each lane places a new
// entry by a combinational compare over its register row and a one-step shift.
// Reset: fill counts clear, the kept length returns to 16 (or LEADERS if less);
// stored entries are left as they are and are never read before written.
// busy is high during reset and for the first cycle after it; the receiver
// cannot stall.
module multi_list_top_k_keeper
    import mlk_pkg::*;
#(
    parameter int LISTS   = LISTS_DEF,
    parameter int LEADERS = LEADERS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_req        i_req,
    output logic        o_done,
    output t_res        o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int FW      = $clog2(LEADERS + 1);
    localparam int LEN_RST = (LEN_RESET > LEADERS) ? LEADERS : LEN_RESET;

    // The block is ready from the cycle after reset lifts and stays ready, since
    // every lane finishes its insert in the cycle it is accepted.
    logic r_busy;
    logic w_accept;
    logic w_ins;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy     = r_busy;
    assign w_accept = start && !r_busy;
    assign w_ins    = w_accept && (i_req.req_type == REQ_INSERT);

    // Configuration: the only register is word zero of the port; the byte
    // offset bits of the address are ignored. The written length is held
    // already clamped to the range one to LEADERS.
    logic [FW-1:0]        r_lim;
    logic [FW-1:0]        n_lim;
    logic                 w_cfg_wr;
    logic [LEN_CFG_W-1:0] w_len_raw;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign w_len_raw = pwdata[LEN_CFG_W-1:0];
    assign prdata    = 32'(r_lim);

    always_comb begin
        if (w_len_raw == '0) begin
            n_lim = FW'(1);
        end else if (int'(w_len_raw) > LEADERS) begin
            n_lim = FW'(LEADERS);
        end else begin
            n_lim = FW'(w_len_raw);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim <= FW'(LEN_RST);
        end else if (w_cfg_wr) begin
            r_lim <= n_lim;
        end
    end

    // The request word carries one score per possible list; lanes take theirs
    // by position.
    logic signed [SCORE_W-1:0] w_scores [MAX_LISTS];

    assign w_scores[0] = i_req.score_a;
    assign w_scores[1] = i_req.score_b;
    assign w_scores[2] = i_req.score_c;
    assign w_scores[3] = i_req.score_d;

    logic [LISTS-1:0] w_kept;
    t_lane_rd         w_rd [LISTS];

    for (genvar l = 0; l < LISTS; l++) begin : g_lane
        mlk_lane #(
            .LEADERS (LEADERS)
        ) u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ins     (w_ins),
            .i_id      (i_req.item_id),
            .i_score   (w_scores[l]),
            .i_lim     (r_lim),
            .i_clamp   (w_cfg_wr),
            .i_new_lim (n_lim),
            .i_rank    (i_req.rank_sel),
            .o_kept    (w_kept[l]),
            .o_rd      (w_rd[l])
        );
    end

    // The merge stage works on the lanes' state from before this insert, so a
    // read sees everything accepted up to the previous word.
    mlk_merge #(
        .LISTS (LISTS)
    ) u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_req_type (i_req.req_type),
        .i_list_sel (i_req.list_sel),
        .i_kept     (w_kept),
        .i_rd       (w_rd),
        .o_done     (o_done),
        .o_res      (o_res)
    );

    // Every accepted word yields exactly one result in the following cycle.
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_done)
        else $error("result strobe missing after an accepted word");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> !o_done)
        else $error("result strobe without an accepted word");

    // A read result never reports kept lists, and a found entry is a read.
    a_read_no_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.out_valid) |-> (o_res.kept_mask == '0))
        else $error("read result carries a kept mask");

    // The kept length never reaches zero.
    a_lim_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lim != '0)
        else $error("kept length is zero");

endmodule
